@@ rtl/nbdc_pkg.sv @@
// Shared types, codes and arithmetic helpers for the naive Bayes digit classifier.
package nbdc_pkg;

  localparam int CLS_W   = 4;
  localparam int SCORE_W = 32;
  localparam int LOG_W   = 16;
  // Widest table address the image side range can ask for (64 x 64 pixels).
  localparam int ADDR_W  = 12;

  localparam logic signed [SCORE_W-1:0] REJECT_RESET = -32'sd89600;

  // Characters that mark a set pixel; a space and everything else is clear.
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_HASH = 8'h23;

  localparam logic [1:0] REQ_LOAD_FEAT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_PRIOR = 2'd1;
  localparam logic [1:0] REQ_PIXEL      = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FEAT  = 2'd1,
    KIND_PRIOR = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_t;

  // One word as it travels down the row of class cells.
  typedef struct packed {
    kind_t                kind;
    logic [CLS_W-1:0]     cls;
    logic [ADDR_W-1:0]    addr;
    logic [2*LOG_W-1:0]   feat;
    logic [LOG_W-1:0]     prior;
    logic                 set;
    logic                 add_en;
    logic                 last;
    logic                 size_err;
  } item_word_t;

  // Running best score handed from cell to cell.
  typedef struct packed {
    logic                       valid;
    logic [CLS_W-1:0]           cls;
    logic signed [SCORE_W-1:0]  score;
    logic                       size_err;
  } best_t;

  typedef struct packed {
    logic [CLS_W-1:0]           cls;
    logic signed [SCORE_W-1:0]  score;
    logic                       size_err;
  } result_t;

  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end
    return s[SCORE_W-1:0];
  endfunction

  function automatic logic signed [SCORE_W-1:0] sext_log(input logic [LOG_W-1:0] v);
    return {{(SCORE_W-LOG_W){v[LOG_W-1]}}, v};
  endfunction

endpackage

@@ rtl/nbdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nbdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 784
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

@@ rtl/nbdc_cell.sv @@
// One class cell: its slice of the log table, prior, accumulator and argmax step.
module nbdc_cell #(
  parameter int ID     = 0,
  parameter int PIXELS = 784
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nbdc_pkg::item_word_t word_i,
  output nbdc_pkg::item_word_t word_o,
  input  nbdc_pkg::best_t    best_i,
  output nbdc_pkg::best_t    best_o
);

  localparam int  PIX_AW   = $clog2(PIXELS);
  localparam logic IS_FIRST = (ID == 0);
  localparam logic [nbdc_pkg::CLS_W-1:0] MY_CLS = nbdc_pkg::CLS_W'(ID);

  nbdc_pkg::item_word_t word_r;
  logic [2*nbdc_pkg::LOG_W-1:0] rd_data;
  logic [nbdc_pkg::LOG_W-1:0]   prior_r;
  logic signed [nbdc_pkg::SCORE_W-1:0] acc_r, acc_sum, term;
  logic signed [nbdc_pkg::SCORE_W-1:0] fin_r, score;
  logic [nbdc_pkg::LOG_W-1:0]   fin_prior_r;
  logic                         fin_valid_r, fin_err_r;
  logic                         hit, take_own;
  nbdc_pkg::best_t              best_r;

  assign hit = (word_i.cls == MY_CLS);

  nbdc_ram #(
    .WIDTH (2*nbdc_pkg::LOG_W),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    ((word_i.kind == nbdc_pkg::KIND_FEAT) && hit),
    .waddr (word_i.addr[PIX_AW-1:0]),
    .wdata (word_i.feat),
    .raddr (word_i.addr[PIX_AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.kind <= nbdc_pkg::KIND_NONE;
    end else begin
      word_r.kind <= word_i.kind;
    end
    word_r.cls      <= word_i.cls;
    word_r.addr     <= word_i.addr;
    word_r.feat     <= word_i.feat;
    word_r.prior    <= word_i.prior;
    word_r.set      <= word_i.set;
    word_r.add_en   <= word_i.add_en;
    word_r.last     <= word_i.last;
    word_r.size_err <= word_i.size_err;
    if ((word_i.kind == nbdc_pkg::KIND_PRIOR) && hit) begin
      prior_r <= word_i.prior;
    end
  end

  assign word_o = word_r;

  // The table read issued with the word lands alongside the registered word in the next cycle.
  assign term = nbdc_pkg::sext_log(word_r.set ? rd_data[2*nbdc_pkg::LOG_W-1:nbdc_pkg::LOG_W]
                                              : rd_data[nbdc_pkg::LOG_W-1:0]);
  assign acc_sum = word_r.add_en ? nbdc_pkg::sat_add(acc_r, term) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= (word_r.kind == nbdc_pkg::KIND_PIXEL) && word_r.last;
      if (word_r.kind == nbdc_pkg::KIND_PIXEL) begin
        acc_r <= word_r.last ? '0 : acc_sum;
      end
    end
    fin_r       <= acc_sum;
    fin_prior_r <= prior_r;
    fin_err_r   <= word_r.size_err;
  end

  // The previous cell's best arrives in the same cycle as this cell's final score.
  assign score    = nbdc_pkg::sat_add(fin_r, nbdc_pkg::sext_log(fin_prior_r));
  assign take_own = IS_FIRST || (score > best_i.score);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.valid <= 1'b0;
    end else begin
      best_r.valid <= fin_valid_r;
    end
    best_r.cls      <= take_own ? MY_CLS : best_i.cls;
    best_r.score    <= take_own ? score : best_i.score;
    best_r.size_err <= fin_err_r;
  end

  assign best_o = best_r;

endmodule

@@ rtl/naive_bayes_digit_classifier_core.sv @@
// Top level of the naive Bayes digit classifier: input framing, cell row and result queue.
// Result path: a last-pixel word accepted at a clock edge is registered at the input and
// hops through the registers of each class cell; the best result then enters the queue.
// Throughput: one input word per cycle of any kind; in_tready drops only when the result
// queue could not hold every result in flight.
// Reset clears the accumulators, pixel counter and queue and restores the threshold.
module naive_bayes_digit_classifier_core #(
  parameter int IMAGE_SIDE  = 28,
  parameter int NUM_CLASSES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // class_label[3:0], pixel_index[13:4], log_if_clear[29:14], log_if_set[45:30],
  // prior_log[61:46], pixel_char[69:62], zero fill[71:70]
  input  logic [71:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // best_class[3:0], best_score[35:4], zero fill[39:36]
  output logic [39:0] out_tdata,
  // size_error[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PIXELS     = IMAGE_SIDE * IMAGE_SIDE;
  localparam int CNT_W      = $clog2(PIXELS + 2);
  localparam int FIFO_DEPTH = 2 ** $clog2(NUM_CLASSES + 6);
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

  logic [3:0]  in_cls;
  logic [9:0]  in_pix;
  logic [7:0]  in_char;
  logic        in_acc, out_acc, last_acc;

  logic signed [nbdc_pkg::SCORE_W-1:0] thr_r;
  logic [CNT_W-1:0]  pix_cnt_r, pix_cnt_nxt, cnt_inc;
  nbdc_pkg::item_word_t word_nxt, word0_r;
  nbdc_pkg::item_word_t word_chain [NUM_CLASSES+1];
  nbdc_pkg::best_t      best_chain [NUM_CLASSES+1];

  nbdc_pkg::result_t fifo_mem [FIFO_DEPTH];
  nbdc_pkg::result_t res_in, res_out;
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CRED_W-1:0]  fcnt_r, cred_r;
  logic               fifo_wr;

  assign in_cls  = in_tdata[3:0];
  assign in_pix  = in_tdata[13:4];
  assign in_char = in_tdata[69:62];

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign last_acc = in_acc && (in_tuser == nbdc_pkg::REQ_PIXEL) && in_tlast;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == nbdc_pkg::REG_THRESHOLD) ? thr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= nbdc_pkg::REJECT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == nbdc_pkg::REG_THRESHOLD)) begin
      thr_r <= cfg_pwdata;
    end
  end

  // Pixel counter stops one past a full image so that an overlong image is flagged.
  assign cnt_inc = (pix_cnt_r <= CNT_W'(PIXELS)) ? pix_cnt_r + CNT_W'(1) : pix_cnt_r;

  always_comb begin
    word_nxt          = '0;
    word_nxt.cls      = in_cls;
    word_nxt.feat     = in_tdata[45:14];
    word_nxt.prior    = in_tdata[61:46];
    word_nxt.set      = (in_char == nbdc_pkg::CHAR_PLUS) || (in_char == nbdc_pkg::CHAR_HASH);
    word_nxt.add_en   = (pix_cnt_r < CNT_W'(PIXELS));
    word_nxt.last     = in_tlast;
    word_nxt.size_err = (cnt_inc != CNT_W'(PIXELS));
    word_nxt.addr     = nbdc_pkg::ADDR_W'(in_pix);
    pix_cnt_nxt       = pix_cnt_r;
    case (in_tuser)
      nbdc_pkg::REQ_LOAD_FEAT: begin
        if ((32'(in_cls) < NUM_CLASSES) && (32'(in_pix) < PIXELS)) begin
          word_nxt.kind = nbdc_pkg::KIND_FEAT;
        end
      end
      nbdc_pkg::REQ_LOAD_PRIOR: begin
        if (32'(in_cls) < NUM_CLASSES) begin
          word_nxt.kind = nbdc_pkg::KIND_PRIOR;
        end
      end
      nbdc_pkg::REQ_PIXEL: begin
        word_nxt.kind = nbdc_pkg::KIND_PIXEL;
        word_nxt.addr = nbdc_pkg::ADDR_W'(pix_cnt_r);
        pix_cnt_nxt   = in_tlast ? '0 : cnt_inc;
      end
      default: begin
        word_nxt.kind = nbdc_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r    <= '0;
      word0_r.kind <= nbdc_pkg::KIND_NONE;
    end else begin
      word0_r.kind <= in_acc ? word_nxt.kind : nbdc_pkg::KIND_NONE;
      if (in_acc) begin
        pix_cnt_r <= pix_cnt_nxt;
      end
    end
    word0_r.cls      <= word_nxt.cls;
    word0_r.addr     <= word_nxt.addr;
    word0_r.feat     <= word_nxt.feat;
    word0_r.prior    <= word_nxt.prior;
    word0_r.set      <= word_nxt.set;
    word0_r.add_en   <= word_nxt.add_en;
    word0_r.last     <= word_nxt.last;
    word0_r.size_err <= word_nxt.size_err;
  end

  // Row of class cells; each word and each running best moves one cell per cycle.
  assign word_chain[0] = word0_r;
  assign best_chain[0] = '0;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cell
    nbdc_cell #(
      .ID     (c),
      .PIXELS (PIXELS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (word_chain[c]),
      .word_o (word_chain[c+1]),
      .best_i (best_chain[c]),
      .best_o (best_chain[c+1])
    );
  end

  // Reject check and result queue.
  assign fifo_wr = best_chain[NUM_CLASSES].valid;
  always_comb begin
    res_in.cls      = best_chain[NUM_CLASSES].cls;
    res_in.score    = best_chain[NUM_CLASSES].score;
    res_in.size_err = best_chain[NUM_CLASSES].size_err;
    if (best_chain[NUM_CLASSES].score <= thr_r) begin
      res_in.cls = nbdc_pkg::CLS_W'(NUM_CLASSES);
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem[wr_ptr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      cred_r   <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fcnt_r <= fcnt_r + CRED_W'(fifo_wr) - CRED_W'(out_acc);
      cred_r <= cred_r + CRED_W'(last_acc) - CRED_W'(out_acc);
    end
  end

  // Every result still in the cell row already owns a queue slot.
  assign in_tready = (cred_r < CRED_W'(FIFO_DEPTH));

  assign res_out    = fifo_mem[rd_ptr_r];
  assign out_tvalid = (fcnt_r != '0);
  assign out_tdata  = {4'b0000, res_out.score, res_out.cls};
  assign out_tuser  = res_out.size_err;

endmodule

@@ rtl/nbdc_checker.sv @@
// Port-level checker for the naive Bayes digit classifier, bound to the top level.
module nbdc_checker #(
  parameter int NUM_CLASSES = 10
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  logic [7:0] pend_r;
  logic       last_acc, out_acc;

  assign last_acc = in_tvalid && in_tready && (in_tuser == nbdc_pkg::REQ_PIXEL) && in_tlast;
  assign out_acc  = out_tvalid && out_tready;

  // Images that ended at the input and have not yet been reported.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(last_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 8'd0)
    else $error("result word without a finished image");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[3:0]) <= NUM_CLASSES)
    else $error("best class out of range");

endmodule

bind naive_bayes_digit_classifier_core nbdc_checker #(.NUM_CLASSES(NUM_CLASSES)) u_nbdc_checker (.*);

@@ tb/sv/nbdc_verdict_checker.sv @@
// Checker for the naive Bayes digit classifier: predicts each image verdict and compares it.
module nbdc_verdict_checker #(
  parameter int IMAGE_SIDE  = 28,
  parameter int NUM_CLASSES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // class_label[3:0], pixel_index[13:4], log_if_clear[29:14], log_if_set[45:30],
  // prior_log[61:46], pixel_char[69:62], zero fill[71:70]
  input  logic [71:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // best_class[3:0], best_score[35:4], zero fill[39:36]
  input  logic [39:0] out_tdata,
  // size_error[0]
  input  logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  localparam int PIXELS = IMAGE_SIDE * IMAGE_SIDE;
  localparam logic [2:0] THRESH_ADDR = {nbdc_pkg::REG_THRESHOLD, 2'b00};
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // Clear term in the low half of an entry, set term in the high half.
  logic [31:0]        term_table [NUM_CLASSES*PIXELS];
  logic [15:0]        prior_table [NUM_CLASSES];
  logic signed [31:0] class_sums [NUM_CLASSES];
  int                 pixels_seen;
  logic signed [31:0] threshold;
  nbdc_pkg::result_t  pending_verdicts [$];
  nbdc_pkg::result_t  want;
  nbdc_pkg::result_t  got;

  function automatic logic signed [31:0] add_clamped(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    longint sum;
    sum = longint'(a) + longint'(b);
    if (sum > SUM_MAX) return 32'sh7FFFFFFF;
    if (sum < SUM_MIN) return 32'sh80000000;
    return sum[31:0];
  endfunction

  task automatic score_pixel(input logic [7:0] ch, input logic last_px);
    logic               set_px;
    logic [31:0]        entry;
    logic [15:0]        term;
    logic signed [31:0] score;
    logic signed [31:0] top_score;
    int                 top_class;
    nbdc_pkg::result_t  verdict;
    // Pixels past the end of the image only move the counter, which stops one past full.
    if (pixels_seen < PIXELS) begin
      set_px = (ch == nbdc_pkg::CHAR_PLUS) || (ch == nbdc_pkg::CHAR_HASH);
      for (int c = 0; c < NUM_CLASSES; c++) begin
        entry = term_table[c*PIXELS + pixels_seen];
        term = set_px ? entry[31:16] : entry[15:0];
        class_sums[c] = add_clamped(class_sums[c], 32'(signed'(term)));
      end
    end
    if (pixels_seen <= PIXELS) pixels_seen++;
    if (last_px) begin
      top_class = 0;
      top_score = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        score = add_clamped(class_sums[c], 32'(signed'(prior_table[c])));
        // Strictly greater, so a tie keeps the lower class.
        if (c == 0 || score > top_score) begin
          top_score = score;
          top_class = c;
        end
      end
      if (top_score <= threshold) top_class = NUM_CLASSES;
      verdict.cls      = top_class[nbdc_pkg::CLS_W-1:0];
      verdict.score    = top_score;
      verdict.size_err = (pixels_seen != PIXELS);
      pending_verdicts = {pending_verdicts, verdict};
      foreach (class_sums[c]) class_sums[c] = '0;
      pixels_seen = 0;
    end
  endtask

  task automatic take_word();
    logic [3:0] cls;
    logic [9:0] pix;
    cls = in_tdata[3:0];
    pix = in_tdata[13:4];
    case (in_tuser)
      nbdc_pkg::REQ_LOAD_FEAT: begin
        if (cls < NUM_CLASSES && pix < PIXELS)
          term_table[int'(cls)*PIXELS + int'(pix)] = {in_tdata[45:30], in_tdata[29:14]};
      end
      nbdc_pkg::REQ_LOAD_PRIOR: begin
        if (cls < NUM_CLASSES) prior_table[cls] = in_tdata[61:46];
      end
      nbdc_pkg::REQ_PIXEL: begin
        score_pixel(in_tdata[69:62], in_tlast);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    results_seen++;
    got.cls      = out_tdata[3:0];
    got.score    = out_tdata[35:4];
    got.size_err = out_tuser;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: unexpected result word: class %0d score %0d size_error %0b",
               $time, got.cls, got.score, got.size_err);
      mismatches++;
    end else begin
      want = pending_verdicts.pop_front();
      if (got.cls !== want.cls) begin
        $display("%0t: best_class expected %0d, got %0d", $time, want.cls, got.cls);
        mismatches++;
      end
      if (got.score !== want.score) begin
        $display("%0t: best_score expected %0d, got %0d", $time, want.score, got.score);
        mismatches++;
      end
      if (got.size_err !== want.size_err) begin
        $display("%0t: size_error expected %0b, got %0b", $time, want.size_err, got.size_err);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (class_sums[c]) class_sums[c] = '0;
      pixels_seen = 0;
      threshold = nbdc_pkg::REJECT_RESET;
      pending_verdicts.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == THRESH_ADDR)
        threshold = cfg_pwdata;
      if (in_tvalid && in_tready) take_word();
      if (out_tvalid && out_tready) check_result();
    end
    outstanding = pending_verdicts.size();
  end

endmodule

@@ tb/sv/naive_bayes_digit_classifier_core_test.sv @@
// Testbench top for the naive Bayes digit classifier: table fill, image stimulus and verdict.
module naive_bayes_digit_classifier_core_test;

  localparam int IMAGE_SIDE     = 28;
  localparam int NUM_CLASSES    = 10;
  localparam int PIXELS         = IMAGE_SIDE * IMAGE_SIDE;
  // Images stay within the first pixels, so only their table entries are filled up front.
  localparam int FILLED_PIXELS  = 32;
  localparam int RESULT_LATENCY = NUM_CLASSES + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [2:0] THRESH_ADDR = {nbdc_pkg::REG_THRESHOLD, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int images_sent = 0;
  int gap_ahead = 0;
  int rx_hold = 0;
  int idle_cycles = 0;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;

  always #1 clk = ~clk;

  naive_bayes_digit_classifier_core #(
    .IMAGE_SIDE(IMAGE_SIDE),
    .NUM_CLASSES(NUM_CLASSES)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  nbdc_verdict_checker #(
    .IMAGE_SIDE(IMAGE_SIDE),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  // Result side: after each accepted word, stay ready or stall at random, with eager stretches.
  always @(posedge clk) begin : result_sink
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
      stall = (rx_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_hold <= stall - 1;
      end
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly small magnitudes so full images land near typical thresholds.
  function automatic logic [15:0] rand_log();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h0000;
    if (r < 5) return 16'(0 - $urandom_range(0, 32768));
    return 16'(0 - $urandom_range(0, 300));
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 3))
      0: return CHAR_SPACE;
      1: return nbdc_pkg::CHAR_PLUS;
      2: return nbdc_pkg::CHAR_HASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic [1:0] req, input logic [3:0] cls, input logic [9:0] pix,
                           input logic [15:0] lc, input logic [15:0] ls, input logic [15:0] pr,
                           input logic [7:0] ch, input logic last);
    if (gap_ahead > 0) repeat (gap_ahead) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, ch, pr, ls, lc, pix, cls};
    in_tuser <= req;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 31) == 0) tx_eager = !tx_eager;
    gap_ahead = tx_eager ? 0 : $urandom_range(0, 10);
    // Valid stays up only when the next word follows at once.
    if (gap_ahead > 0) in_tvalid <= 1'b0;
  endtask

  task automatic load_terms(input logic [3:0] cls, input logic [9:0] pix,
                            input logic [15:0] lc, input logic [15:0] ls);
    send_word(nbdc_pkg::REQ_LOAD_FEAT, cls, pix, lc, ls, rand_log(),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic load_prior(input logic [3:0] cls, input logic [15:0] pr);
    send_word(nbdc_pkg::REQ_LOAD_PRIOR, cls, 10'($urandom_range(0, 1023)), rand_log(),
              rand_log(), pr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic put_pixel(input logic [7:0] ch, input logic last);
    send_word(nbdc_pkg::REQ_PIXEL, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
              rand_log(), rand_log(), rand_log(), ch, last);
    if (last) images_sent++;
  endtask

  task automatic send_image(input int n);
    for (int i = 0; i < n; i++) put_pixel(rand_char(), i == n - 1);
  endtask

  task automatic send_noise();
    send_word(REQ_UNUSED, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)), rand_log(),
              rand_log(), rand_log(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // The threshold only changes with no image in flight and the cell row drained.
  task automatic write_threshold(input logic signed [31:0] value);
    if (gap_ahead == 0) in_tvalid <= 1'b0;
    wait (results_seen == images_sent);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= THRESH_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    logic signed [31:0] level;
    logic [15:0] lc;
    logic [15:0] ls;
    int sent;
    int n;
    int r;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every prior and the table entries of the first pixels, so no image ever reads
    // an unwritten one. Equal priors and equal low pixels make ties; pixel 1 favors
    // classes four and seven.
    for (int c = 0; c < NUM_CLASSES; c++) load_prior(4'(c), 16'h0000);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int p = 0; p < FILLED_PIXELS; p++) begin
        case (p)
          0: begin lc = 16'h0000; ls = -16'sd256; end
          1: begin
            if (c == 0) begin lc = 16'h8000; ls = 16'h8000; end
            else if (c == 4 || c == 7) begin lc = 16'h0000; ls = 16'h0000; end
            else begin lc = -16'sd100; ls = -16'sd100; end
          end
          2: begin lc = 16'h0000; ls = 16'h8000; end
          3: begin lc = 16'h8000; ls = 16'h0000; end
          default: begin lc = rand_log(); ls = rand_log(); end
        endcase
        load_terms(4'(c), 10'(p), lc, ls);
      end
    end

    // Character decoding, ties and one- and two-pixel images under the reset threshold.
    put_pixel(CHAR_SPACE, 1'b1);
    put_pixel(nbdc_pkg::CHAR_PLUS, 1'b1);
    put_pixel(nbdc_pkg::CHAR_HASH, 1'b1);
    put_pixel(8'hFF, 1'b1);
    put_pixel(8'h00, 1'b1);
    put_pixel(CHAR_SPACE, 1'b0);
    put_pixel(CHAR_SPACE, 1'b1);
    // Ignored words (unused request, loads out of range), then in-range priors for classes nine and zero.
    send_word(REQ_UNUSED, 4'd0, 10'd0, 16'h0000, 16'h0000, 16'h0000, nbdc_pkg::CHAR_PLUS, 1'b1);
    load_terms(4'd15, 10'd0, 16'h0000, 16'h0000);
    load_terms(4'd2, 10'd1023, 16'h0000, 16'h0000);
    load_terms(4'd0, 10'(PIXELS), 16'h0000, 16'h0000);
    load_prior(4'd12, 16'h8000);
    load_prior(4'd9, 16'h8000);
    load_prior(4'd0, 16'h0000);
    put_pixel(CHAR_SPACE, 1'b0);
    put_pixel(nbdc_pkg::CHAR_PLUS, 1'b0);
    put_pixel(nbdc_pkg::CHAR_HASH, 1'b1);

    // Threshold at zero: a score of exactly zero is rejected.
    write_threshold(32'sd0);
    put_pixel(CHAR_SPACE, 1'b1);
    put_pixel(nbdc_pkg::CHAR_PLUS, 1'b1);
    // Threshold at its bottom: nothing is rejected.
    write_threshold(32'sh80000000);
    put_pixel(nbdc_pkg::CHAR_PLUS, 1'b1);
    send_image(FILLED_PIXELS);

    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk)
        0, 4: level = 32'(0 - $urandom_range(0, 400000));
        1: level = 32'sd0;
        2: level = nbdc_pkg::REJECT_RESET;
        3: level = {1'b1, 31'($urandom)};
        default: level = 32'sh80000000;
      endcase
      write_threshold(level);
      if (chunk == 1) send_image(FILLED_PIXELS);
      if (chunk == 3) send_image(FILLED_PIXELS - 1);
      sent = 0;
      while (sent < 110) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          // Short image, now and then with a table update slipped in between pixels.
          n = $urandom_range(1, 24);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
              load_terms(4'($urandom_range(0, NUM_CLASSES - 1)), 10'($urandom_range(0, 31)),
                         rand_log(), rand_log());
            put_pixel(rand_char(), i == n - 1);
          end
          sent += n;
        end else if (r < 78) begin
          load_terms(4'($urandom_range(0, NUM_CLASSES - 1)),
                     ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 31))
                                                 : 10'($urandom_range(0, PIXELS - 1)),
                     rand_log(), rand_log());
          sent++;
        end else if (r < 86) begin
          load_prior(4'($urandom_range(0, 15)), rand_log());
          sent++;
        end else if (r < 93) begin
          if ($urandom_range(0, 1) == 0)
            load_terms(4'($urandom_range(NUM_CLASSES, 15)), 10'($urandom_range(0, 1023)),
                       rand_log(), rand_log());
          else
            load_terms(4'($urandom_range(0, 15)), 10'($urandom_range(PIXELS, 1023)),
                       rand_log(), rand_log());
          sent++;
        end else begin
          send_noise();
          sent++;
        end
      end
    end

    if (gap_ahead == 0) in_tvalid <= 1'b0;
    wait (results_seen == images_sent);
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/nbdc_pkg.sv
rtl/nbdc_ram.sv
rtl/nbdc_cell.sv
rtl/naive_bayes_digit_classifier_core.sv
rtl/nbdc_checker.sv
tb/sv/nbdc_verdict_checker.sv
tb/sv/naive_bayes_digit_classifier_core_test.sv
